FILE: sv/wpas_pkg.sv
package wpas_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 24;
	localparam int ID_W       = 16;
	localparam int SPEED_W    = 16;
	localparam int RADIUS_W   = 16;
	localparam int LEN_W      = 40;

	// |a - b| of two coordinates, its square sum, root and partial remainder
	localparam int MAG_W  = COORD_W + 1;
	localparam int DSQ_W  = 2 * MAG_W;
	localparam int ROOT_W = MAG_W;
	localparam int REM_W  = MAG_W + 1;
	localparam int STEP_W = $clog2(MAG_W);

	localparam logic [RADIUS_W-1:0] REACH_RADIUS_RST = RADIUS_W'(160);
	localparam logic [CNT_W-1:0]    CNT_MAX          = CNT_W'(MAX_POINTS);
	localparam logic [LEN_W-1:0]    LEN_SAT          = '1;

	// register map
	localparam int  ADDR_W           = 3;
	localparam logic REG_REACH_RADIUS = 1'b0;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_REPORT = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [SPEED_W-1:0]        speed;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// start / finish of the distance unit
	typedef struct packed {
		logic start;
	} dist_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} dist_rsp_t;

endpackage

FILE: sv/wpas_if.sv
interface wpas_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             action;
	logic [wpas_pkg::ID_W-1:0]              wp_id;
	logic signed [wpas_pkg::COORD_W-1:0]    pos_x;
	logic signed [wpas_pkg::COORD_W-1:0]    pos_y;
	logic signed [wpas_pkg::COORD_W-1:0]    pos_z;
	logic [wpas_pkg::SPEED_W-1:0]           wp_speed;

	modport source (output valid, action, wp_id, pos_x, pos_y, pos_z, wp_speed, input ready);
	modport sink   (input valid, action, wp_id, pos_x, pos_y, pos_z, wp_speed, output ready);
endinterface

interface wpas_out_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   reached;
	logic                                   table_full;
	logic [6:0]                             target_index;
	logic [6:0]                             route_count;
	logic [wpas_pkg::LEN_W-1:0]             route_length;
	logic                                   target_valid;
	logic [wpas_pkg::ID_W-1:0]              target_id;
	logic signed [wpas_pkg::COORD_W-1:0]    target_x;
	logic signed [wpas_pkg::COORD_W-1:0]    target_y;
	logic signed [wpas_pkg::COORD_W-1:0]    target_z;
	logic [wpas_pkg::SPEED_W-1:0]           target_speed;

	modport source (output valid, reached, table_full, target_index, route_count,
		route_length, target_valid, target_id, target_x, target_y, target_z,
		target_speed, input ready);
	modport sink   (input valid, reached, table_full, target_index, route_count,
		route_length, target_valid, target_id, target_x, target_y, target_z,
		target_speed, output ready);
endinterface

FILE: sv/waypoint_arrival_sequencer_top.sv
// Waypoint route sequencer. Holds up to 64 waypoints (id, signed 24-bit x/y/z in
// 1/16 m, speed) in one on-chip RAM. An append stores a waypoint and adds the
// floor square root of its squared distance from the previous waypoint to a
// 40-bit route length that saturates at all ones; when the table is full the
// append is dropped and table_full is set. A position report advances the
// target index and sets reached when the squared distance to the current
// target is below reach_radius squared (tested as isqrt(d2) < reach_radius,
// which is the same thing for an integer radius). A clear empties the route.
// Every request returns exactly one result describing the target after the
// step; target fields read zero past the end of the route. A request that
// needs a distance (append with a previous waypoint, report with a valid
// target) passes bit-serial squaring and 25 root steps in the distance unit,
// plus RAM reads and the table update; other requests skip the distance unit.
// Only one request is in work at a time; a new one is accepted while the
// previous result still waits on the output. reach_radius sits at APB byte
// address 0 (reset 160); the user must write it only while the block is
// idle, and the block itself does not enforce this. Stored entries carry no
// reset; their data is only used once written.
module waypoint_arrival_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	wpas_in_if.sink                       in_ch,
	wpas_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wpas_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// request sequencer
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,  // take a request, RAM read of the neighbor entry
		S_LOAD = 6'b000010,  // entry data ready, kick the distance unit
		S_WAIT = 6'b000100,  // distance unit busy
		S_UPD  = 6'b001000,  // update table, counters and length
		S_LOOK = 6'b010000,  // RAM read of the new target
		S_DONE = 6'b100000   // load the output register
	} state_t;

	state_t                              state_q;

	// configuration
	logic [wpas_pkg::RADIUS_W-1:0]       radius_q;

	// route state
	logic [wpas_pkg::CNT_W-1:0]          count_q;
	logic [wpas_pkg::CNT_W-1:0]          target_q;
	logic [wpas_pkg::LEN_W-1:0]          len_q;

	// latched request
	wpas_pkg::action_t                   act_q;
	wpas_pkg::entry_t                    req_q;
	logic                                full_q;
	logic                                reached_q;

	// output register
	logic                                ovalid_q;
	logic                                o_reached_q;
	logic                                o_full_q;
	logic [wpas_pkg::CNT_W-1:0]          o_index_q;
	logic [wpas_pkg::CNT_W-1:0]          o_count_q;
	logic [wpas_pkg::LEN_W-1:0]          o_len_q;
	logic                                o_tvalid_q;
	wpas_pkg::entry_t                    o_entry_q;

	// RAM port
	logic                                ram_we;
	logic [wpas_pkg::IDX_W-1:0]          ram_waddr;
	logic [wpas_pkg::IDX_W-1:0]          ram_raddr;
	logic [wpas_pkg::ENTRY_W-1:0]        ram_rdata;
	wpas_pkg::entry_t                    rd_entry;

	// distance unit
	wpas_pkg::dist_req_t                 dreq;
	wpas_pkg::dist_rsp_t                 drsp;

	logic                                in_fire;
	logic                                cfg_wr;
	logic                                can_append;
	logic                                has_target;
	logic                                need_dist;
	logic                                out_free;
	logic [wpas_pkg::LEN_W:0]            len_sum;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == wpas_pkg::REG_REACH_RADIUS) begin
			prdata = 32'(radius_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= wpas_pkg::REACH_RADIUS_RST;
		end else if (cfg_wr && paddr[2] == wpas_pkg::REG_REACH_RADIUS) begin
			radius_q <= pwdata[wpas_pkg::RADIUS_W-1:0];
		end
	end

	// ---------------------------------------------------------------- control
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid & in_ch.ready;
	assign out_free    = !ovalid_q || out_ch.ready;

	assign can_append  = (count_q < wpas_pkg::CNT_MAX);
	assign has_target  = (target_q < count_q);

	// the segment length needs a previous entry; a report needs a target
	always_comb begin
		need_dist = 1'b0;
		case (act_q)
			wpas_pkg::ACT_APPEND: need_dist = can_append && (count_q != '0);
			wpas_pkg::ACT_REPORT: need_dist = has_target;
			default:              need_dist = 1'b0;
		endcase
	end

	assign dreq.start = (state_q == S_LOAD) && need_dist;

	// RAM read: neighbor at request time, target in every other state so the
	// read data holds while the result waits for the output register
	always_comb begin
		if (state_q == S_IDLE && in_ch.action == wpas_pkg::ACT_APPEND) begin
			ram_raddr = wpas_pkg::IDX_W'(count_q - 1'b1);
		end else begin
			ram_raddr = target_q[wpas_pkg::IDX_W-1:0];
		end
	end

	assign ram_we    = (state_q == S_UPD) && (act_q == wpas_pkg::ACT_APPEND) && can_append;
	assign ram_waddr = count_q[wpas_pkg::IDX_W-1:0];
	assign rd_entry  = wpas_pkg::entry_t'(ram_rdata);

	assign len_sum = {1'b0, len_q} + (wpas_pkg::LEN_W + 1)'(drsp.root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			target_q  <= '0;
			len_q     <= '0;
			ovalid_q  <= 1'b0;
			act_q     <= wpas_pkg::ACT_APPEND;
			full_q    <= 1'b0;
			reached_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						act_q     <= wpas_pkg::action_t'(in_ch.action);
						full_q    <= 1'b0;
						reached_q <= 1'b0;
						state_q   <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= need_dist ? S_WAIT : S_UPD;
				end
				S_WAIT: begin
					if (drsp.done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					case (act_q)
						wpas_pkg::ACT_APPEND: begin
							if (!can_append) begin
								full_q <= 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
								if (need_dist) begin
									len_q <= len_sum[wpas_pkg::LEN_W] ? wpas_pkg::LEN_SAT
										: len_sum[wpas_pkg::LEN_W-1:0];
								end
							end
						end
						wpas_pkg::ACT_REPORT: begin
							if (has_target && drsp.root < wpas_pkg::ROOT_W'(radius_q)) begin
								target_q  <= target_q + 1'b1;
								reached_q <= 1'b1;
							end
						end
						wpas_pkg::ACT_CLEAR: begin
							count_q  <= '0;
							target_q <= '0;
							len_q    <= '0;
						end
						default: begin
						end
					endcase
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q.id    <= in_ch.wp_id;
			req_q.x     <= in_ch.pos_x;
			req_q.y     <= in_ch.pos_y;
			req_q.z     <= in_ch.pos_z;
			req_q.speed <= in_ch.wp_speed;
		end
		if (state_q == S_DONE && out_free) begin
			o_reached_q <= reached_q;
			o_full_q    <= full_q;
			o_index_q   <= target_q;
			o_count_q   <= count_q;
			o_len_q     <= len_q;
			o_tvalid_q  <= has_target;
			o_entry_q   <= has_target ? rd_entry : '0;
		end
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.reached      = o_reached_q;
	assign out_ch.table_full   = o_full_q;
	assign out_ch.target_index = 7'(o_index_q);
	assign out_ch.route_count  = 7'(o_count_q);
	assign out_ch.route_length = o_len_q;
	assign out_ch.target_valid = o_tvalid_q;
	assign out_ch.target_id    = o_entry_q.id;
	assign out_ch.target_x     = o_entry_q.x;
	assign out_ch.target_y     = o_entry_q.y;
	assign out_ch.target_z     = o_entry_q.z;
	assign out_ch.target_speed = o_entry_q.speed;

	// ---------------------------------------------------------------- units
	wpas_ram #(
		.WIDTH(wpas_pkg::ENTRY_W),
		.DEPTH(wpas_pkg::MAX_POINTS)
	) u_route (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wpas_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.pt_x   (req_q.x),
		.pt_y   (req_q.y),
		.pt_z   (req_q.z),
		.wp_x   (rd_entry.x),
		.wp_y   (rd_entry.y),
		.wp_z   (rd_entry.z),
		.rsp    (drsp)
	);

endmodule

FILE: sv/wpas_ram.sv
module wpas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/wpas_dist.sv
// Bit-serial |p - w|: squares MSB first (all three axes per cycle),
// then digit-by-digit integer root, two radicand bits per step.
module wpas_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wpas_pkg::dist_req_t                 req,
	input  logic signed [wpas_pkg::COORD_W-1:0] pt_x,
	input  logic signed [wpas_pkg::COORD_W-1:0] pt_y,
	input  logic signed [wpas_pkg::COORD_W-1:0] pt_z,
	input  logic signed [wpas_pkg::COORD_W-1:0] wp_x,
	input  logic signed [wpas_pkg::COORD_W-1:0] wp_y,
	input  logic signed [wpas_pkg::COORD_W-1:0] wp_z,
	output wpas_pkg::dist_rsp_t                 rsp
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_MUL  = 3'b010,
		D_ROOT = 3'b100
	} dphase_t;

	localparam logic [wpas_pkg::STEP_W-1:0] LAST_STEP = wpas_pkg::STEP_W'(wpas_pkg::MAG_W - 1);

	dphase_t                          phase_q;
	logic [wpas_pkg::STEP_W-1:0]      step_q;
	logic [wpas_pkg::MAG_W-1:0]       mag_q [3];
	logic [wpas_pkg::MAG_W-1:0]       mul_q [3];
	logic [wpas_pkg::DSQ_W-1:0]       acc_q;
	logic [wpas_pkg::REM_W-1:0]       rem_q;
	logic [wpas_pkg::ROOT_W-1:0]      root_q;
	logic                             done_q;

	logic [wpas_pkg::MAG_W-1:0]       diff [3];
	logic [wpas_pkg::MAG_W-1:0]       mag_d [3];
	logic [wpas_pkg::DSQ_W-1:0]       acc_mul;
	logic [wpas_pkg::REM_W+1:0]       rem_shift;
	logic [wpas_pkg::REM_W+1:0]       trial;
	logic                             take;

	always_comb begin
		diff[0] = {pt_x[wpas_pkg::COORD_W-1], pt_x} - {wp_x[wpas_pkg::COORD_W-1], wp_x};
		diff[1] = {pt_y[wpas_pkg::COORD_W-1], pt_y} - {wp_y[wpas_pkg::COORD_W-1], wp_y};
		diff[2] = {pt_z[wpas_pkg::COORD_W-1], pt_z} - {wp_z[wpas_pkg::COORD_W-1], wp_z};
		for (int a = 0; a < 3; a++) begin
			mag_d[a] = diff[a][wpas_pkg::MAG_W-1] ? (~diff[a] + 1'b1) : diff[a];
		end
	end

	always_comb begin
		acc_mul = {acc_q[wpas_pkg::DSQ_W-2:0], 1'b0};
		for (int a = 0; a < 3; a++) begin
			if (mul_q[a][wpas_pkg::MAG_W-1]) begin
				acc_mul = acc_mul + wpas_pkg::DSQ_W'(mag_q[a]);
			end
		end
	end

	assign rem_shift = {rem_q, acc_q[wpas_pkg::DSQ_W-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign take      = (rem_shift >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= D_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			case (phase_q)
				D_IDLE: begin
					done_q <= 1'b0;
					if (req.start) begin
						phase_q <= D_MUL;
						step_q  <= '0;
					end
				end
				D_MUL: begin
					done_q <= 1'b0;
					if (step_q == LAST_STEP) begin
						phase_q <= D_ROOT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				D_ROOT: begin
					if (step_q == LAST_STEP) begin
						phase_q <= D_IDLE;
						done_q  <= 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
						done_q <= 1'b0;
					end
				end
				default: begin
					phase_q <= D_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			D_IDLE: begin
				if (req.start) begin
					for (int a = 0; a < 3; a++) begin
						mag_q[a] <= mag_d[a];
						mul_q[a] <= mag_d[a];
					end
					acc_q <= '0;
				end
			end
			D_MUL: begin
				acc_q <= acc_mul;
				for (int a = 0; a < 3; a++) begin
					mul_q[a] <= {mul_q[a][wpas_pkg::MAG_W-2:0], 1'b0};
				end
				if (step_q == LAST_STEP) begin
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			D_ROOT: begin
				acc_q <= {acc_q[wpas_pkg::DSQ_W-3:0], 2'b00};
				if (take) begin
					rem_q  <= wpas_pkg::REM_W'(rem_shift - trial);
					root_q <= {root_q[wpas_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= wpas_pkg::REM_W'(rem_shift);
					root_q <= {root_q[wpas_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

FILE: bench/tb_waypoint_arrival_sequencer_top.sv
`timescale 1ns / 1ps

module tb_waypoint_arrival_sequencer_top;

	// action code 3 is not a real action: the block only reports its status
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic signed [wpas_pkg::COORD_W-1:0] CMAX =
		{1'b0, {(wpas_pkg::COORD_W-1){1'b1}}};
	localparam logic signed [wpas_pkg::COORD_W-1:0] CMIN =
		{1'b1, {(wpas_pkg::COORD_W-1){1'b0}}};

	localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_AFTER    = 100;   // result count that starts the long output stall
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 205;
	localparam int PHASES        = 6;

	typedef struct packed {
		logic [1:0]                          action;
		logic [wpas_pkg::ID_W-1:0]           id;
		logic signed [wpas_pkg::COORD_W-1:0] x;
		logic signed [wpas_pkg::COORD_W-1:0] y;
		logic signed [wpas_pkg::COORD_W-1:0] z;
		logic [wpas_pkg::SPEED_W-1:0]        speed;
	} nav_req_t;

	typedef struct packed {
		logic                                reached;
		logic                                table_full;
		logic [6:0]                          target_index;
		logic [6:0]                          route_count;
		logic [wpas_pkg::LEN_W-1:0]          route_length;
		logic                                target_valid;
		logic [wpas_pkg::ID_W-1:0]           id;
		logic signed [wpas_pkg::COORD_W-1:0] x;
		logic signed [wpas_pkg::COORD_W-1:0] y;
		logic signed [wpas_pkg::COORD_W-1:0] z;
		logic [wpas_pkg::SPEED_W-1:0]        speed;
	} nav_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	// APB side, idle from time zero
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [wpas_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	wpas_in_if  nav_in();
	wpas_out_if nav_out();

	waypoint_arrival_sequencer_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (nav_in),
		.out_ch  (nav_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Route predictor: own copy of the waypoint table and the radius.
	// Run once per accepted request, in acceptance order.
	// ------------------------------------------------------------------
	logic signed [wpas_pkg::COORD_W-1:0] route_x [wpas_pkg::MAX_POINTS];
	logic signed [wpas_pkg::COORD_W-1:0] route_y [wpas_pkg::MAX_POINTS];
	logic signed [wpas_pkg::COORD_W-1:0] route_z [wpas_pkg::MAX_POINTS];
	logic [wpas_pkg::ID_W-1:0]           route_id [wpas_pkg::MAX_POINTS];
	logic [wpas_pkg::SPEED_W-1:0]        route_speed [wpas_pkg::MAX_POINTS];
	int                                  route_n = 0;
	int                                  aim_idx = 0;
	logic [wpas_pkg::LEN_W-1:0]          path_len = '0;
	logic [wpas_pkg::RADIUS_W-1:0]       reach_r = wpas_pkg::REACH_RADIUS_RST;

	nav_req_t    req_backlog[$];  // requests waiting for the driver
	nav_status_t status_due[$];   // predicted results, oldest first
	int          real_items = 0;  // generated requests with a real action
	int          mismatches = 0;

	// squared Euclidean distance; 3 * (2^24)^2 stays well inside 64 bits
	function automatic logic [63:0] span_sq(logic signed [wpas_pkg::COORD_W-1:0] ax, ay, az,
		logic signed [wpas_pkg::COORD_W-1:0] bx, by, bz);
		longint dx, dy, dz;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		dz = longint'(az) - longint'(bz);
		return 64'(dx * dx + dy * dy + dz * dz);
	endfunction

	// floor square root, one result bit at a time from the top
	function automatic logic [63:0] floor_root(logic [63:0] n);
		logic [63:0] root, trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	task automatic advance_route(nav_req_t rq);
		nav_status_t st;
		logic [63:0] seg;
		st = '0;
		case (rq.action)
			wpas_pkg::ACT_APPEND: begin
				if (route_n >= wpas_pkg::MAX_POINTS) begin
					st.table_full = 1'b1;
				end else begin
					// first waypoint has no segment in front of it
					if (route_n > 0) begin
						seg = floor_root(span_sq(rq.x, rq.y, rq.z, route_x[route_n-1],
							route_y[route_n-1], route_z[route_n-1]));
						if (seg > 64'(wpas_pkg::LEN_SAT) - 64'(path_len))
							path_len = wpas_pkg::LEN_SAT;
						else
							path_len = path_len + seg[wpas_pkg::LEN_W-1:0];
					end
					route_x[route_n]     = rq.x;
					route_y[route_n]     = rq.y;
					route_z[route_n]     = rq.z;
					route_id[route_n]    = rq.id;
					route_speed[route_n] = rq.speed;
					route_n++;
				end
			end
			wpas_pkg::ACT_REPORT: begin
				// no target past the end: nothing moves
				if (aim_idx < route_n && span_sq(rq.x, rq.y, rq.z, route_x[aim_idx],
					route_y[aim_idx], route_z[aim_idx]) < 64'(reach_r) * 64'(reach_r)) begin
					aim_idx++;
					st.reached = 1'b1;
				end
			end
			wpas_pkg::ACT_CLEAR: begin
				route_n  = 0;
				aim_idx  = 0;
				path_len = '0;
			end
			default: ;
		endcase
		st.target_index = 7'(aim_idx);
		st.route_count  = 7'(route_n);
		st.route_length = path_len;
		if (aim_idx < route_n) begin
			st.target_valid = 1'b1;
			st.id    = route_id[aim_idx];
			st.x     = route_x[aim_idx];
			st.y     = route_y[aim_idx];
			st.z     = route_z[aim_idx];
			st.speed = route_speed[aim_idx];
		end
		status_due.insert(status_due.size(), st);
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic match_field(string name, logic signed [63:0] want, logic signed [63:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			mismatches++;
		end
	endtask

	task automatic check_status(nav_status_t got);
		nav_status_t want;
		if (status_due.size() == 0) begin
			$error("result with no request outstanding");
			mismatches++;
			return;
		end
		want = status_due.pop_front();
		match_field("reached",      want.reached,      got.reached);
		match_field("table_full",   want.table_full,   got.table_full);
		match_field("target_index", want.target_index, got.target_index);
		match_field("route_count",  want.route_count,  got.route_count);
		match_field("route_length", want.route_length, got.route_length);
		match_field("target_valid", want.target_valid, got.target_valid);
		match_field("target_id",    want.id,           got.id);
		match_field("target_x",     want.x,            got.x);
		match_field("target_y",     want.y,            got.y);
		match_field("target_z",     want.z,            got.z);
		match_field("target_speed", want.speed,        got.speed);
	endtask

	// ------------------------------------------------------------------
	// Request driver: pops the backlog, random gap after each accepted
	// request, with calm stretches where the gap is always zero.
	// ------------------------------------------------------------------
	int       in_wait = 0;
	bit       in_calm = 1'b0;
	nav_req_t next_req;
	nav_req_t took_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nav_in.valid    <= 1'b0;
			nav_in.action   <= '0;
			nav_in.wp_id    <= '0;
			nav_in.pos_x    <= '0;
			nav_in.pos_y    <= '0;
			nav_in.pos_z    <= '0;
			nav_in.wp_speed <= '0;
			in_wait = 0;
		end else begin
			if (nav_in.valid && nav_in.ready) begin
				took_req.action = nav_in.action;
				took_req.id     = nav_in.wp_id;
				took_req.x      = nav_in.pos_x;
				took_req.y      = nav_in.pos_y;
				took_req.z      = nav_in.pos_z;
				took_req.speed  = nav_in.wp_speed;
				advance_route(took_req);
				if ($urandom_range(0, 31) == 0)
					in_calm = !in_calm;
				in_wait = in_calm ? 0 : $urandom_range(0, 5);
			end
			if (!nav_in.valid || nav_in.ready) begin
				if (in_wait > 0) begin
					in_wait--;
					nav_in.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					next_req = req_backlog.pop_front();
					nav_in.action   <= next_req.action;
					nav_in.wp_id    <= next_req.id;
					nav_in.pos_x    <= next_req.x;
					nav_in.pos_y    <= next_req.y;
					nav_in.pos_z    <= next_req.z;
					nav_in.wp_speed <= next_req.speed;
					nav_in.valid    <= 1'b1;
				end else begin
					nav_in.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random stall after each result, one long hold-off
	// so the block backs up and stalls its input.
	// ------------------------------------------------------------------
	int          out_wait = 0;
	bit          out_calm = 1'b0;
	int          results_seen = 0;
	nav_status_t got_status;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nav_out.ready <= 1'b0;
			out_wait = 0;
		end else begin
			if (nav_out.valid && nav_out.ready) begin
				got_status.reached      = nav_out.reached;
				got_status.table_full   = nav_out.table_full;
				got_status.target_index = nav_out.target_index;
				got_status.route_count  = nav_out.route_count;
				got_status.route_length = nav_out.route_length;
				got_status.target_valid = nav_out.target_valid;
				got_status.id           = nav_out.target_id;
				got_status.x            = nav_out.target_x;
				got_status.y            = nav_out.target_y;
				got_status.z            = nav_out.target_z;
				got_status.speed        = nav_out.target_speed;
				check_status(got_status);
				results_seen++;
				if ($urandom_range(0, 31) == 0)
					out_calm = !out_calm;
				out_wait = out_calm ? 0 : $urandom_range(0, 5);
				if (results_seen == HOLD_AFTER)
					out_wait = HOLD_CYCLES;
			end
			if (out_wait > 0) begin
				out_wait--;
				nav_out.ready <= 1'b0;
			end else begin
				nav_out.ready <= 1'b1;
			end
		end
	end

	// watchdog: any handshake on either stream port or any APB write restarts the count
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (nav_in.valid && nav_in.ready) || (nav_out.valid && nav_out.ready)
			|| (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_item(logic [1:0] act, logic [wpas_pkg::ID_W-1:0] id,
		logic signed [wpas_pkg::COORD_W-1:0] x, y, z, logic [wpas_pkg::SPEED_W-1:0] speed);
		nav_req_t rq;
		rq.action = act;
		rq.id     = id;
		rq.x      = x;
		rq.y      = y;
		rq.z      = z;
		rq.speed  = speed;
		req_backlog.insert(req_backlog.size(), rq);
		if (act != ACT_NONE)
			real_items++;
	endtask

	function automatic logic signed [wpas_pkg::COORD_W-1:0] any_coord();
		return wpas_pkg::COORD_W'($urandom());
	endfunction

	function automatic logic signed [wpas_pkg::COORD_W-1:0] pin_coord(longint v);
		if (v > longint'(CMAX))
			return CMAX;
		if (v < longint'(CMIN))
			return CMIN;
		return wpas_pkg::COORD_W'(v);
	endfunction

	// uniform in [-m, m]
	function automatic longint spread(longint m);
		return longint'($urandom_range(0, 32'(2 * m))) - m;
	endfunction

	function automatic logic signed [wpas_pkg::COORD_W-1:0] edge_coord();
		return $urandom_range(0, 1) ? CMAX : CMIN;
	endfunction

	// One route run: usually clear, append a route, then walk it with
	// position reports (mostly inside the radius, some on the boundary,
	// some far off). A few runs skip the clear or are pure noise.
	task automatic make_route_run();
		logic signed [wpas_pkg::COORD_W-1:0] way_x [70];
		logic signed [wpas_pkg::COORD_W-1:0] way_y [70];
		logic signed [wpas_pkg::COORD_W-1:0] way_z [70];
		int     pick, n, style, tries, kind, targets;
		longint half, wide_m, bound;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			repeat ($urandom_range(1, 4))
				push_item(2'($urandom_range(0, 3)), 16'($urandom()), any_coord(),
					any_coord(), any_coord(), 16'($urandom()));
			return;
		end
		if (pick != 1)
			push_item(wpas_pkg::ACT_CLEAR, 16'($urandom()), any_coord(), any_coord(),
				any_coord(), 16'($urandom()));
		pick = $urandom_range(0, 19);
		if (pick < 14)
			n = $urandom_range(1, 8);
		else if (pick < 18)
			n = $urandom_range(9, 40);
		else  // runs into a full table
			n = $urandom_range(wpas_pkg::MAX_POINTS - 2, wpas_pkg::MAX_POINTS + 4);
		style = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			if (style == 0) begin
				way_x[i] = any_coord();
				way_y[i] = any_coord();
				way_z[i] = any_coord();
			end else if (style == 1) begin
				way_x[i] = edge_coord();
				way_y[i] = edge_coord();
				way_z[i] = edge_coord();
			end else if (i == 0) begin
				way_x[i] = pin_coord(spread(100000));
				way_y[i] = pin_coord(spread(100000));
				way_z[i] = pin_coord(spread(2000));
			end else begin
				way_x[i] = pin_coord(longint'(way_x[i-1]) + spread(4096));
				way_y[i] = pin_coord(longint'(way_y[i-1]) + spread(4096));
				way_z[i] = pin_coord(longint'(way_z[i-1]) + spread(256));
			end
			push_item(wpas_pkg::ACT_APPEND, 16'($urandom()), way_x[i], way_y[i], way_z[i],
				16'($urandom()));
		end
		half    = longint'(reach_r) / 2;
		wide_m  = 2 * longint'(reach_r) + 64;
		targets = (n < wpas_pkg::MAX_POINTS) ? n : wpas_pkg::MAX_POINTS;
		for (int j = 0; j < targets; j++) begin
			tries = $urandom_range(1, 3);
			for (int t = 0; t < tries; t++) begin
				kind = $urandom_range(0, 19);
				if (kind < 10) begin
					push_item(wpas_pkg::ACT_REPORT, 16'($urandom()),
						pin_coord(longint'(way_x[j]) + spread(half)),
						pin_coord(longint'(way_y[j]) + spread(half)),
						pin_coord(longint'(way_z[j]) + spread(half)), 16'($urandom()));
				end else if (kind < 13) begin
					// on the radius (miss) or just inside it
					bound = longint'(reach_r) - longint'($urandom_range(0, 1));
					if ($urandom_range(0, 1))
						bound = -bound;
					push_item(wpas_pkg::ACT_REPORT, 16'($urandom()),
						pin_coord(longint'(way_x[j]) + bound), way_y[j], way_z[j],
						16'($urandom()));
				end else begin
					push_item(wpas_pkg::ACT_REPORT, 16'($urandom()),
						pin_coord(longint'(way_x[j]) + spread(wide_m)),
						pin_coord(longint'(way_y[j]) + spread(wide_m)),
						pin_coord(longint'(way_z[j]) + spread(wide_m)), 16'($urandom()));
				end
			end
		end
		if ($urandom_range(0, 2) == 0)
			push_item(wpas_pkg::ACT_REPORT, 16'($urandom()), any_coord(), any_coord(),
				any_coord(), 16'($urandom()));
	endtask

	// register write: setup cycle, then access cycle until pready
	task automatic set_reach_radius(logic [wpas_pkg::RADIUS_W-1:0] r);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= wpas_pkg::ADDR_W'(4 * wpas_pkg::REG_REACH_RADIUS);
		pwdata  <= 32'(r);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reach_r = r;
	endtask

	// idle = nothing queued, nothing offered, nothing outstanding
	task automatic wait_route_idle();
		while (req_backlog.size() != 0 || nav_in.valid || status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int                            phase_start;
		logic [wpas_pkg::RADIUS_W-1:0] radius;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset radius
		push_item(wpas_pkg::ACT_REPORT, 16'h0000, 24'sd0, 24'sd0, 24'sd0, 16'h0000); // empty route
		push_item(ACT_NONE, 16'hFFFF, CMAX, CMIN, CMAX, 16'hFFFF);                   // unused code
		push_item(wpas_pkg::ACT_APPEND, 16'hFFFF, CMAX, CMIN, 24'sd0, 16'hFFFF);     // first append
		push_item(wpas_pkg::ACT_APPEND, 16'h0000, CMIN, CMAX, CMAX, 16'h0000);   // longest segment
		push_item(wpas_pkg::ACT_APPEND, 16'h5A5A, 24'sd0, 24'sd0, CMIN, 16'hA5A5);
		push_item(wpas_pkg::ACT_REPORT, 16'h1234, CMAX, CMIN, 24'sd0, 16'h4321);     // exact hit
		push_item(wpas_pkg::ACT_REPORT, 16'h0000, CMIN + 24'sd160, CMAX, CMAX,
			16'h0000);                                                               // on radius: miss
		push_item(wpas_pkg::ACT_REPORT, 16'hFFFF, CMIN + 24'sd159, CMAX, CMAX,
			16'hFFFF);                                                               // just inside
		push_item(ACT_NONE, 16'h0000, 24'sd0, 24'sd0, 24'sd0, 16'h0000);
		push_item(wpas_pkg::ACT_REPORT, 16'h0000, CMAX, CMAX, CMAX, 16'h0000);       // far miss
		push_item(wpas_pkg::ACT_REPORT, 16'h0000, 24'sd0, 24'sd0, CMIN, 16'h0000);   // last target
		push_item(wpas_pkg::ACT_REPORT, 16'h0000, 24'sd0, 24'sd0, CMIN, 16'h0000);   // past the end
		push_item(wpas_pkg::ACT_APPEND, 16'h0001, 24'sd1, -24'sd1, 24'sd1, 16'h0001); // target again
		push_item(wpas_pkg::ACT_CLEAR, 16'hFFFF, CMAX, CMAX, CMAX, 16'hFFFF);
		push_item(wpas_pkg::ACT_REPORT, 16'h0000, 24'sd0, 24'sd0, 24'sd0, 16'h0000); // after clear
		push_item(wpas_pkg::ACT_APPEND, 16'h8001, -24'sd1, 24'sd1, -24'sd1, 16'h8001);

		// random phases, each at its own radius; zero and all-ones included
		for (int p = 0; p < PHASES; p++) begin
			wait_route_idle();
			case (p)
				0:       radius = '0;
				1:       radius = '1;
				2:       radius = wpas_pkg::RADIUS_W'(1);
				3:       radius = wpas_pkg::REACH_RADIUS_RST;
				4:       radius = wpas_pkg::RADIUS_W'($urandom_range(2, 400));
				default: radius = wpas_pkg::RADIUS_W'($urandom());
			endcase
			set_reach_radius(radius);
			phase_start = real_items;
			while (real_items - phase_start < PHASE_ITEMS)
				make_route_run();
		end

		wait_route_idle();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
